// ===== rtl/core/tensor_index_add_engine_assert.svh =====
// Assertion macros for the scatter-add engine.
`ifndef TENSOR_INDEX_ADD_ENGINE_ASSERT_SVH
`define TENSOR_INDEX_ADD_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TIAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TIAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tiae_pkg.sv =====
`default_nettype none

package tiae_pkg;

  // Field widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 12;
  localparam int CFG_W     = 13;
  localparam int IN_VAL_W  = 32;
  localparam int OUT_VAL_W = 32;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int VALUE_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COUNT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/tensor_index_add_engine.sv =====
// Channel   Ports                                        Transfer
// input     in_operation, in_dest_index, in_slice_position,
//           in_value, in_last_add                        start & !busy
// result    out_read_value, out_out_of_range,
//           out_batch_done                               out_valid (one cycle)
// config    cfg_index, cfg_wdata                         cfg_we
//
// Add: 12 restoring divide steps on one subtractor, then two passes through one
// 26x13 multiplier, a bound check and a read-modify-write; result strobe in the
// cycle after the last busy one, in which the next start can already be taken.
// Load and read pass S_RD, then S_UPD (store read is registered). No operation: S_UPD only.
// Reset idles the sequencer and sets the config registers to 1; the store is not cleared.
// The result side cannot stall: out_valid is high for exactly one cycle.
`default_nettype none

`include "tensor_index_add_engine_assert.svh"

module tensor_index_add_engine #(
  parameter int STORE_DEPTH = tiae_pkg::STORE_DEPTH_DEF,
  parameter int VALUE_WIDTH = tiae_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [tiae_pkg::OP_W-1:0]            in_operation,
  input  wire logic [tiae_pkg::IDX_W-1:0]           in_dest_index,
  input  wire logic [tiae_pkg::IDX_W-1:0]           in_slice_position,
  input  wire logic signed [tiae_pkg::IN_VAL_W-1:0] in_value,
  input  wire logic                                 in_last_add,
  // result channel
  output logic                                      out_valid,
  output logic signed [tiae_pkg::OUT_VAL_W-1:0]     out_read_value,
  output logic                                      out_out_of_range,
  output logic                                      out_batch_done,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [tiae_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tiae_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW      = (VALUE_WIDTH > tiae_pkg::IN_VAL_W) ? VALUE_WIDTH : tiae_pkg::IN_VAL_W;
  localparam int EW      = CW + 1;
  localparam int CNT_W   = $clog2(tiae_pkg::IDX_W);
  localparam int MUL_A_W = tiae_pkg::IDX_W + tiae_pkg::CFG_W + 1;
  localparam int MUL_B_W = tiae_pkg::CFG_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int OFF_W   = PROD_W + 1;

  localparam logic signed [EW-1:0] VMAX =
    {{(EW + 1 - VALUE_WIDTH){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN = ~VMAX;
  localparam logic signed [EW-1:0] OMAX =
    {{(EW + 1 - tiae_pkg::OUT_VAL_W){1'b0}}, {(tiae_pkg::OUT_VAL_W - 1){1'b1}}};
  localparam logic signed [EW-1:0] OMIN = ~OMAX;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_SUM  = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_RD   = 8'b0100_0000,
    S_UPD  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [tiae_pkg::CFG_W-1:0] inner_size_r, index_count_r, outer_count_r;
  logic [tiae_pkg::CFG_W-1:0] inner_eff, icnt_eff, ocnt_eff;

  tiae_pkg::op_t                     op_r;
  logic [tiae_pkg::IDX_W-1:0]        di_r;
  logic signed [tiae_pkg::IN_VAL_W-1:0] val_r;
  logic                              last_r;
  logic                              oor_r;
  logic [AW-1:0]                     addr_r;
  logic [CNT_W-1:0]                  cnt_r;

  // divider
  logic [tiae_pkg::CFG_W-1:0]        rem_r;
  logic [tiae_pkg::IDX_W-1:0]        quo_r;
  logic [tiae_pkg::CFG_W:0]          trial;
  logic                              trial_ge;

  // shared multiplier
  logic [MUL_A_W-1:0]                mul_a;
  logic [MUL_B_W-1:0]                mul_b;
  logic [PROD_W-1:0]                 mul_p;
  logic [PROD_W-1:0]                 prod_r;
  logic [MUL_A_W-1:0]                lin_r;
  logic [OFF_W-1:0]                  off;
  logic                              add_oor;

  // store
  logic signed [VALUE_WIDTH-1:0]     mem [STORE_DEPTH];
  logic signed [VALUE_WIDTH-1:0]     mem_q;
  logic                              mem_we;

  // update datapath
  logic signed [EW-1:0]              ld_ext, ld_sat, sum_ext, sum_sat, new_ext;
  logic signed [tiae_pkg::OUT_VAL_W-1:0] res32;
  logic                              in_oor;
  logic                              accept;

  logic                              out_valid_r;
  logic signed [tiae_pkg::OUT_VAL_W-1:0] out_value_r;
  logic                              out_oor_r;
  logic                              out_done_r;

  assign inner_eff = (inner_size_r  == '0) ? tiae_pkg::CFG_W'(1) : inner_size_r;
  assign icnt_eff  = (index_count_r == '0) ? tiae_pkg::CFG_W'(1) : index_count_r;
  assign ocnt_eff  = (outer_count_r == '0) ? tiae_pkg::CFG_W'(1) : outer_count_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_oor = (OFF_W'(in_dest_index) >= OFF_W'(STORE_DEPTH));

  // restoring divide step: slice_position / inner_size
  assign trial    = {rem_r, quo_r[tiae_pkg::IDX_W-1]};
  assign trial_ge = (trial >= {1'b0, inner_eff});

  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = MUL_A_W'(quo_r);
        mul_b = icnt_eff;
      end
      default: begin
        mul_a = lin_r;
        mul_b = inner_eff;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign off     = OFF_W'(prod_r) + OFF_W'(rem_r);
  assign add_oor = (di_r >= icnt_eff[tiae_pkg::IDX_W-1:0] && icnt_eff[tiae_pkg::CFG_W-1] == 1'b0)
                || (OFF_W'(quo_r) >= OFF_W'(ocnt_eff))
                || (off >= OFF_W'(STORE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (tiae_pkg::op_t'(in_operation))
            tiae_pkg::OP_ADD: state_nxt = S_DIV;
            tiae_pkg::OP_NOP: state_nxt = S_UPD;
            default:          state_nxt = S_RD;
          endcase
        end
      end
      S_DIV:   if (cnt_r == CNT_W'(tiae_pkg::IDX_W - 1)) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_CHK;
      S_CHK:   state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      inner_size_r  <= tiae_pkg::CFG_W'(1);
      index_count_r <= tiae_pkg::CFG_W'(1);
      outer_count_r <= tiae_pkg::CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_UPD);
      if (state_r == S_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (cfg_we) begin
        case (cfg_index)
          tiae_pkg::CFG_INNER_SIZE:  inner_size_r  <= cfg_wdata;
          tiae_pkg::CFG_INDEX_COUNT: index_count_r <= cfg_wdata;
          tiae_pkg::CFG_OUTER_COUNT: outer_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // item datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r   <= tiae_pkg::op_t'(in_operation);
          di_r   <= in_dest_index;
          val_r  <= in_value;
          last_r <= in_last_add;
          quo_r  <= in_slice_position;
          rem_r  <= '0;
          addr_r <= AW'(in_dest_index);
          oor_r  <= (tiae_pkg::op_t'(in_operation) != tiae_pkg::OP_NOP) && in_oor;
        end
      end
      S_DIV: begin
        quo_r <= {quo_r[tiae_pkg::IDX_W-2:0], trial_ge};
        rem_r <= trial_ge ? tiae_pkg::CFG_W'(trial - {1'b0, inner_eff})
                          : trial[tiae_pkg::CFG_W-1:0];
      end
      S_MUL1:  prod_r <= mul_p;
      S_SUM:   lin_r  <= prod_r[MUL_A_W-1:0] + MUL_A_W'(di_r);
      S_MUL2:  prod_r <= mul_p;
      S_CHK: begin
        oor_r  <= add_oor;
        addr_r <= off[AW-1:0];
      end
      default: ;
    endcase
  end

  // store: one registered read, one write
  assign mem_we = (state_r == S_UPD) && !oor_r
               && (op_r == tiae_pkg::OP_LOAD || op_r == tiae_pkg::OP_ADD);

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      mem_q <= mem[addr_r];
    end
    if (mem_we) begin
      mem[addr_r] <= new_ext[VALUE_WIDTH-1:0];
    end
  end

  // saturating update in a widened signed domain
  assign ld_ext  = EW'(val_r);
  assign ld_sat  = (ld_ext > VMAX) ? VMAX : ((ld_ext < VMIN) ? VMIN : ld_ext);
  assign sum_ext = EW'(mem_q) + EW'(val_r);
  assign sum_sat = (sum_ext > VMAX) ? VMAX : ((sum_ext < VMIN) ? VMIN : sum_ext);

  always_comb begin
    case (op_r)
      tiae_pkg::OP_LOAD: new_ext = ld_sat;
      tiae_pkg::OP_ADD:  new_ext = sum_sat;
      tiae_pkg::OP_READ: new_ext = EW'(mem_q);
      default:           new_ext = '0;
    endcase
  end

  always_comb begin
    if (oor_r) begin
      res32 = '0;
    end else if (new_ext > OMAX) begin
      res32 = OMAX[tiae_pkg::OUT_VAL_W-1:0];
    end else if (new_ext < OMIN) begin
      res32 = OMIN[tiae_pkg::OUT_VAL_W-1:0];
    end else begin
      res32 = new_ext[tiae_pkg::OUT_VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      out_value_r <= res32;
      out_oor_r   <= oor_r;
      out_done_r  <= (op_r == tiae_pkg::OP_ADD) && last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_out_of_range = out_oor_r;
  assign out_batch_done   = out_done_r;

  `TIAE_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted item did not raise busy")
  `TIAE_ASSERT_NOW(a_strobe_after_work, clk, rst_n, out_valid, !busy && $past(busy),
    "result strobe not at end of work")
  `TIAE_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_out_of_range, out_read_value == '0,
    "dropped item returned nonzero value")
  `TIAE_ASSERT_NOW(a_no_write_oor, clk, rst_n, mem_we, !oor_r, "store written for dropped item")

endmodule

`default_nettype wire
